// ----- rtl/core/skt_pkg.sv -----
// Shared types and codes of the sorted key table.
package skt_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int KEY_W     = 32;
   localparam int PAY_W     = 32;
   localparam int ACT_W     = 3;
   localparam int CNT_OUT_W = 5;

   localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_REM_FIRST = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REM_LAST  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_REM_KEY   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_LOOKUP    = 3'd4;

   typedef struct packed {
      logic [ACT_W-1:0]        action;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        record_payload;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [PAY_W-1:0]     found_payload;
      logic [CNT_OUT_W-1:0] entry_count;
   } rsp_type;

   // Request token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic                    active;
      logic                    en;
      logic [ACT_W-1:0]        action;
      logic signed [KEY_W-1:0] key;
      logic signed [KEY_W-1:0] carry_key;
      logic [PAY_W-1:0]        carry_pay;
      logic                    hit;
      logic [PAY_W-1:0]        found_pay;
   } tok_type;

endpackage

// ----- rtl/core/sorted_key_table.sv -----
// Top level of the sorted key table: a row of entry cells walked by each request.
//
// Usage:
//  - req_valid/req_stall/req_data carry one request: insert, remove first,
//    remove last, remove by key or look up. A request is taken when
//    req_valid is high and req_stall is low.
//  - rsp_valid/rsp_stall/rsp_data return exactly one response per request:
//    success flag, payload involved and the count after the action.
//  - A request enters cell 0 at the edge that takes it and moves one cell per
//    cycle down the row; cells shift entries with their neighbor as it passes.
//    The result then passes the holding register into the response register.
//  - One request is in the row at a time, so a new request is taken only
//    after the walk over the DEPTH cells ends and its result has left the
//    holding register.
//  - While a response waits under rsp_stall, the next request may still be
//    taken and walk the row; its result parks in a holding register and
//    req_stall stays high until that register drains.
//  - Reset empties the table (count zero) and drops any request in flight;
//    entry contents are not cleared and need not be.
module sorted_key_table import skt_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(DEPTH);

   tok_type                 tok_w [DEPTH+1];
   logic signed [KEY_W-1:0] key_w [DEPTH];
   logic [PAY_W-1:0]        pay_w [DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff;
   logic             pend_vld_ff;
   rsp_type          pend_ff;
   logic             rsp_vld_ff;
   rsp_type          rsp_ff;
   logic             req_accept;
   tok_type          tok_new;
   tok_type          tok_done;
   logic [CNT_W+CNT_OUT_W-1:0] count_ext;

   assign req_stall  = busy_ff || pend_vld_ff;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      tok_new           = '0;
      tok_new.active    = 1'b1;
      tok_new.en        = count_ff != DEPTH_V;
      tok_new.action    = req_data.action;
      tok_new.key       = req_data.key;
      tok_new.carry_key = req_data.key;
      tok_new.carry_pay = req_data.record_payload;
   end

   assign tok_w[0] = req_accept ? tok_new : '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [KEY_W-1:0] nbr_key;
      logic [PAY_W-1:0]        nbr_pay;
      if (i == DEPTH - 1) begin : g_last
         assign nbr_key = key_w[i];
         assign nbr_pay = pay_w[i];
      end else begin : g_mid
         assign nbr_key = key_w[i+1];
         assign nbr_pay = pay_w[i+1];
      end
      skt_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_w[i]),
         .tok_out (tok_w[i+1]),
         .count   (count_ff),
         .nbr_key (nbr_key),
         .nbr_pay (nbr_pay),
         .key_out (key_w[i]),
         .pay_out (pay_w[i])
      );
   end

   assign tok_done = tok_w[DEPTH];

   always_comb begin
      count_in = count_ff;
      case (tok_done.action) inside
         ACT_INSERT: begin
            if (tok_done.hit) begin
               count_in = count_ff + 1'b1;
            end
         end
         ACT_REM_FIRST, ACT_REM_LAST, ACT_REM_KEY: begin
            if (tok_done.hit) begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      count_ext = {{CNT_OUT_W{1'b0}}, count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         busy_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (req_accept) begin
            busy_ff <= 1'b1;
         end
         if (tok_done.active) begin
            count_ff              <= count_in;
            busy_ff               <= 1'b0;
            pend_vld_ff           <= 1'b1;
            pend_ff.ok            <= tok_done.hit;
            pend_ff.found_payload <= tok_done.found_pay;
            pend_ff.entry_count   <= count_ext[CNT_OUT_W-1:0];
         end
         if (pend_vld_ff && (!rsp_vld_ff || !rsp_stall)) begin
            rsp_ff      <= pend_ff;
            rsp_vld_ff  <= 1'b1;
            pend_vld_ff <= 1'b0;
         end else if (rsp_vld_ff && !rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      tok_done.active |-> busy_ff)
      else $error("request left the row with no request in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_V)
      else $error("entry count above table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff && !tok_done.active)
      else $error("request not held in the row after acceptance");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !tok_done.active |=> $stable(count_ff))
      else $error("count changed during a walk");

endmodule

// ----- rtl/core/skt_cell.sv -----
// One entry slot of the sorted key table with its stage of the request token.
module skt_cell import skt_pkg::*; #(
   parameter int CNT_W = 5,
   parameter int IDX   = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tok_type                 tok_in,
   output tok_type                 tok_out,
   input  logic [CNT_W-1:0]        count,
   input  logic signed [KEY_W-1:0] nbr_key,
   input  logic [PAY_W-1:0]        nbr_pay,
   output logic signed [KEY_W-1:0] key_out,
   output logic [PAY_W-1:0]        pay_out
);

   localparam logic [CNT_W-1:0] IDX_V  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] IDX1_V = CNT_W'(IDX + 1);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0]        pay_ff, pay_in;
   tok_type                 tok_ff, tok_nx_in;
   logic                    valid;
   logic                    here;
   logic                    match;

   always_comb begin
      valid = IDX_V < count;
      if (IDX == 0) begin
         here = (count == '0) || ($signed(key_ff) > $signed(tok_in.key));
      end else begin
         here = !valid || ($signed(key_ff) >= $signed(tok_in.key));
      end
      if (tok_in.action == ACT_REM_FIRST) begin
         match = (IDX == 0) && valid;
      end else begin
         match = valid && (key_ff == tok_in.key);
      end
   end

   always_comb begin
      tok_nx_in = tok_in;
      key_in    = key_ff;
      pay_in    = pay_ff;
      if (tok_in.active) begin
         case (tok_in.action) inside
            ACT_INSERT: begin
               if (tok_in.en && (tok_in.hit || here)) begin
                  key_in              = tok_in.carry_key;
                  pay_in              = tok_in.carry_pay;
                  tok_nx_in.carry_key = key_ff;
                  tok_nx_in.carry_pay = pay_ff;
                  tok_nx_in.hit       = 1'b1;
               end
            end
            ACT_REM_FIRST, ACT_REM_KEY: begin
               if (tok_in.hit || match) begin
                  key_in = nbr_key;
                  pay_in = nbr_pay;
               end
               if (!tok_in.hit && match) begin
                  tok_nx_in.hit       = 1'b1;
                  tok_nx_in.found_pay = pay_ff;
               end
            end
            ACT_REM_LAST: begin
               if (!tok_in.hit && valid && (IDX1_V == count)) begin
                  tok_nx_in.hit       = 1'b1;
                  tok_nx_in.found_pay = pay_ff;
               end
            end
            ACT_LOOKUP: begin
               if (!tok_in.hit && match) begin
                  tok_nx_in.hit       = 1'b1;
                  tok_nx_in.found_pay = pay_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_nx_in;
      end
   end

   assign tok_out = tok_ff;
   assign key_out = key_ff;
   assign pay_out = pay_ff;

endmodule
